### rtl/msxu_pkg.sv
// ----------------------------------------------------------------------------
// msxu_pkg
// Shared types, operation codes and helpers for the MIPS-subset execute unit.
// ----------------------------------------------------------------------------
package msxu_pkg;

  localparam logic [4:0] K_ADD     = 5'd0;
  localparam logic [4:0] K_ADDI    = 5'd1;
  localparam logic [4:0] K_SUB     = 5'd2;
  localparam logic [4:0] K_AND     = 5'd3;
  localparam logic [4:0] K_OR      = 5'd4;
  localparam logic [4:0] K_XOR     = 5'd5;
  localparam logic [4:0] K_NOR     = 5'd6;
  localparam logic [4:0] K_SLT     = 5'd7;
  localparam logic [4:0] K_BLT     = 5'd8;
  localparam logic [4:0] K_BEQ     = 5'd9;
  localparam logic [4:0] K_BNE     = 5'd10;
  localparam logic [4:0] K_SLTI    = 5'd11;
  localparam logic [4:0] K_ANDI    = 5'd12;
  localparam logic [4:0] K_ORI     = 5'd13;
  localparam logic [4:0] K_XORI    = 5'd14;
  localparam logic [4:0] K_LUI     = 5'd15;
  localparam logic [4:0] K_LW      = 5'd16;
  localparam logic [4:0] K_SW      = 5'd17;
  localparam logic [4:0] K_LB      = 5'd18;
  localparam logic [4:0] K_SB      = 5'd19;
  localparam logic [4:0] K_LBU     = 5'd20;
  localparam logic [4:0] K_SLL     = 5'd21;
  localparam logic [4:0] K_SRL     = 5'd22;
  localparam logic [4:0] K_SRA     = 5'd23;
  localparam logic [4:0] K_JR      = 5'd24;
  localparam logic [4:0] K_J       = 5'd25;
  localparam logic [4:0] K_JAL     = 5'd26;
  localparam logic [4:0] K_SYSCALL = 5'd27;
  localparam logic [4:0] K_MFHI    = 5'd28;
  localparam logic [4:0] K_MFLO    = 5'd29;
  localparam logic [4:0] K_MUL     = 5'd30;

  localparam logic [4:0]  RA_INDEX   = 5'd31;
  localparam logic [4:0]  SYS_REG    = 5'd2;
  localparam logic [4:0]  ARG_REG    = 5'd4;
  localparam logic [31:0] SYS_PRINT_INT  = 32'd1;
  localparam logic [31:0] SYS_EXIT       = 32'd10;
  localparam logic [31:0] SYS_PRINT_CHAR = 32'd11;
  localparam logic [31:0] RESET_PC   = 32'h0040_0000;

  localparam logic [1:0] PK_NONE = 2'd0;
  localparam logic [1:0] PK_INT  = 2'd1;
  localparam logic [1:0] PK_CHAR = 2'd2;

  typedef struct packed {
    logic [4:0]  kind;
    logic [4:0]  dest_reg;
    logic [4:0]  src_reg_a;
    logic [4:0]  src_reg_b;
    logic [15:0] immediate;
    logic [4:0]  shift_amount;
    logic [25:0] jump_target;
  } in_t;

  // One instruction in flight after the operand stage
  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] pc;
    logic        wr;
    logic [4:0]  widx;
    logic [31:0] wval;
    logic        late;     // value known only at the last stage
    logic        memw;
    logic        quit;
    logic [1:0]  pkind;
    logic [31:0] pval;
    logic [31:0] sdata;
    logic [31:0] addr;
    logic [63:0] prod;
  } stg_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_written;
    logic        exit_request;
    logic [1:0]  print_kind;
    logic [31:0] print_value;
  } out_t;

  // Syscall reads r2 and r4 through the two operand ports
  function automatic logic [4:0] rd_addr_a(input in_t i);
    return (i.kind == K_SYSCALL) ? SYS_REG : i.src_reg_a;
  endfunction

  function automatic logic [4:0] rd_addr_b(input in_t i);
    return (i.kind == K_SYSCALL) ? ARG_REG : i.src_reg_b;
  endfunction

endpackage

### rtl/msxu_if.sv
// ----------------------------------------------------------------------------
// msxu interfaces
// Valid/ready channels for instructions, results and configuration.
// ----------------------------------------------------------------------------
interface msxu_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  kind;
  logic [4:0]  dest_reg;
  logic [4:0]  src_reg_a;
  logic [4:0]  src_reg_b;
  logic [15:0] immediate;
  logic [4:0]  shift_amount;
  logic [25:0] jump_target;
  modport source (output valid, kind, dest_reg, src_reg_a, src_reg_b, immediate,
                  shift_amount, jump_target, input ready);
  modport sink (input valid, kind, dest_reg, src_reg_a, src_reg_b, immediate,
                shift_amount, jump_target, output ready);
endinterface

interface msxu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        reg_written;
  logic [4:0]  reg_index;
  logic [31:0] reg_value;
  logic        mem_written;
  logic        exit_request;
  logic [1:0]  print_kind;
  logic [31:0] print_value;
  modport source (output valid, next_pc, reg_written, reg_index, reg_value,
                  mem_written, exit_request, print_kind, print_value, input ready);
  modport sink (input valid, next_pc, reg_written, reg_index, reg_value,
                mem_written, exit_request, print_kind, print_value, output ready);
endinterface

interface msxu_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### rtl/mips_subset_execute_unit.sv
// ----------------------------------------------------------------------------
// mips_subset_execute_unit
// Executes one decoded MIPS-subset instruction per transfer.
// ----------------------------------------------------------------------------
// Four-stage pipe plus an output register: operands/ALU, word-index multiply,
// index remainder and data memory read, memory data and retire. Registers
// live in a 32-entry RAM, data in a DMEM_WORDS-word RAM; both have registered
// reads issued ahead of the stage that uses the data. Sustained rate is one
// instruction per cycle unless a hazard or a result stall holds the pipe. An
// instruction that needs the result of a load, mfhi or mflo still in the pipe
// waits until that producer retires; other results are forwarded. No clearing
// pass.
module mips_subset_execute_unit #(
  parameter int DMEM_WORDS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  msxu_in_if.sink     in_bus,
  msxu_out_if.source  out_bus,
  msxu_cfg_if.sink    cfg_bus
);

  localparam int AW  = $clog2(DMEM_WORDS);
  localparam int DSH = 30 + AW;
  localparam logic [63:0] MAGIC64 =
    ((64'd1 << DSH) + 64'(DMEM_WORDS) - 64'd1) / 64'(DMEM_WORDS);
  localparam logic [31:0] MAGIC = MAGIC64[31:0];
  localparam logic [29:0] DMEM_C = 30'(DMEM_WORDS);

  msxu_pkg::in_t  in_pl, s1_r;
  msxu_pkg::stg_t s1_res, s2_r, s3_r, s4_r;
  msxu_pkg::out_t out_r, out_nxt;

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic s1_move, s2_move, s3_move, s4_move, in_fire, hazard;
  logic [31:0] pc_r, hi_r, lo_r;

  logic [4:0]  ra_a, ra_b, s1_ra, s1_rb;
  logic [31:0] rf_a, rf_b, opa, opb;
  logic [31:0] rv_r;
  logic        rva_r, rvb_r;

  logic        lastc_v_r;
  logic [4:0]  lastc_idx_r;
  logic [31:0] lastc_val_r;

  logic [61:0] qprod;
  logic [29:0] s3_q_r, qc, rem;
  logic [AW-1:0] s4_widx_r;
  logic [31:0] dm_rd, word, fin_val, st_word;
  logic [7:0]  lane_byte;
  logic        dfwd_r;
  logic [31:0] dfd_r;

  assign in_pl = '{kind: in_bus.kind, dest_reg: in_bus.dest_reg,
                   src_reg_a: in_bus.src_reg_a, src_reg_b: in_bus.src_reg_b,
                   immediate: in_bus.immediate, shift_amount: in_bus.shift_amount,
                   jump_target: in_bus.jump_target};

  // ---------------- handshake / flow ----------------
  assign s4_move = s4_v_r && (!out_v_r || out_bus.ready);
  assign s3_move = s3_v_r && (!s4_v_r || s4_move);
  assign s2_move = s2_v_r && (!s3_v_r || s3_move);
  assign s1_move = s1_v_r && (!s2_v_r || s2_move) && !hazard;
  assign in_bus.ready = !s1_v_r || s1_move;
  assign in_fire = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready = 1'b1;

  // ---------------- register file ----------------
  assign s1_ra = msxu_pkg::rd_addr_a(s1_r);
  assign s1_rb = msxu_pkg::rd_addr_b(s1_r);
  // re-read while the operand stage holds so retired writes show up
  assign ra_a = (s1_v_r && !s1_move) ? s1_ra : msxu_pkg::rd_addr_a(in_pl);
  assign ra_b = (s1_v_r && !s1_move) ? s1_rb : msxu_pkg::rd_addr_b(in_pl);

  msxu_ram #(.WIDTH(32), .DEPTH(32)) u_rf (
    .clk(clk), .we(s4_move && s4_r.wr), .waddr(s4_r.widx), .wdata(fin_val),
    .re_a(1'b1), .raddr_a(ra_a), .rdata_a(rf_a),
    .re_b(1'b1), .raddr_b(ra_b), .rdata_b(rf_b)
  );

  function automatic logic late_hit(input logic [4:0] ra, input logic v,
                                    input msxu_pkg::stg_t s);
    return v && s.wr && s.late && (s.widx == ra);
  endfunction

  function automatic logic hit(input logic [4:0] ra, input logic v,
                               input msxu_pkg::stg_t s);
    return v && s.wr && (s.widx == ra);
  endfunction

  function automatic logic [31:0] fwd(input logic [4:0] ra, input logic [31:0] d,
                                      input logic dv);
    logic [31:0] r;
    if (ra == 5'd0) r = 32'd0;
    else if (hit(ra, s2_v_r, s2_r)) r = s2_r.wval;
    else if (hit(ra, s3_v_r, s3_r)) r = s3_r.wval;
    else if (hit(ra, s4_v_r, s4_r)) r = s4_r.wval;
    else if (lastc_v_r && lastc_idx_r == ra) r = lastc_val_r;
    else r = dv ? d : 32'd0;
    return r;
  endfunction

  assign opa = fwd(s1_ra, rf_a, rva_r);
  assign opb = fwd(s1_rb, rf_b, rvb_r);

  assign hazard = (s1_ra != 5'd0 && (late_hit(s1_ra, s2_v_r, s2_r) ||
                   late_hit(s1_ra, s3_v_r, s3_r) || late_hit(s1_ra, s4_v_r, s4_r))) ||
                  (s1_rb != 5'd0 && (late_hit(s1_rb, s2_v_r, s2_r) ||
                   late_hit(s1_rb, s3_v_r, s3_r) || late_hit(s1_rb, s4_v_r, s4_r)));

  msxu_alu u_alu (.ins(s1_r), .a(opa), .b(opb), .pc(pc_r), .res(s1_res));

  // ---------------- data memory index ----------------
  assign qprod = s2_r.addr[31:2] * MAGIC;
  assign qc    = 30'(s3_q_r * DMEM_C);
  assign rem   = s3_r.addr[31:2] - qc;

  msxu_ram #(.WIDTH(32), .DEPTH(DMEM_WORDS)) u_dmem (
    .clk(clk), .we(s4_move && s4_r.memw), .waddr(s4_widx_r), .wdata(st_word),
    .re_a(s3_move), .raddr_a(rem[AW-1:0]), .rdata_a(dm_rd),
    .re_b(1'b0), .raddr_b(rem[AW-1:0]), .rdata_b()
  );

  // ---------------- retire stage ----------------
  assign word = dfwd_r ? dfd_r : dm_rd;

  always_comb begin
    case (s4_r.addr[1:0])
      2'd0: lane_byte = word[31:24];
      2'd1: lane_byte = word[23:16];
      2'd2: lane_byte = word[15:8];
      default: lane_byte = word[7:0];
    endcase
    st_word = s4_r.sdata;
    if (s4_r.kind == msxu_pkg::K_SB) begin
      st_word = word;
      case (s4_r.addr[1:0])
        2'd0: st_word[31:24] = s4_r.sdata[7:0];
        2'd1: st_word[23:16] = s4_r.sdata[7:0];
        2'd2: st_word[15:8]  = s4_r.sdata[7:0];
        default: st_word[7:0] = s4_r.sdata[7:0];
      endcase
    end
    fin_val = s4_r.wval;
    if (s4_r.wr) begin
      case (s4_r.kind)
        msxu_pkg::K_LW:   fin_val = word;
        msxu_pkg::K_LB:   fin_val = {{24{lane_byte[7]}}, lane_byte};
        msxu_pkg::K_LBU:  fin_val = {24'd0, lane_byte};
        msxu_pkg::K_MFHI: fin_val = hi_r;
        msxu_pkg::K_MFLO: fin_val = lo_r;
        default:          fin_val = s4_r.wval;
      endcase
    end
    out_nxt = '{next_pc: s4_r.pc, reg_written: s4_r.wr, reg_index: s4_r.widx,
                reg_value: fin_val, mem_written: s4_r.memw, exit_request: s4_r.quit,
                print_kind: s4_r.pkind, print_value: s4_r.pval};
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      s4_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      pc_r      <= msxu_pkg::RESET_PC;
      hi_r      <= 32'd0;
      lo_r      <= 32'd0;
      rv_r      <= 32'd0;
      rva_r     <= 1'b0;
      rvb_r     <= 1'b0;
      lastc_v_r <= 1'b0;
      dfwd_r    <= 1'b0;
    end else begin
      if (in_fire) s1_v_r <= 1'b1;
      else if (s1_move) s1_v_r <= 1'b0;
      if (s1_move) s2_v_r <= 1'b1;
      else if (s2_move) s2_v_r <= 1'b0;
      if (s2_move) s3_v_r <= 1'b1;
      else if (s3_move) s3_v_r <= 1'b0;
      if (s3_move) s4_v_r <= 1'b1;
      else if (s4_move) s4_v_r <= 1'b0;
      if (s4_move) out_v_r <= 1'b1;
      else if (out_bus.ready) out_v_r <= 1'b0;

      if (cfg_bus.valid) pc_r <= cfg_bus.data;
      else if (s1_move) pc_r <= s1_res.pc;

      rva_r <= rv_r[ra_a];
      rvb_r <= rv_r[ra_b];
      lastc_v_r <= s4_move && s4_r.wr;
      // a store retiring while the next access reads the same word;
      // kept while that access waits in the retire stage
      if (s3_move) begin
        dfwd_r <= s4_move && s4_r.memw && (rem[AW-1:0] == s4_widx_r);
      end
      if (s4_move) begin
        if (s4_r.wr) rv_r[s4_r.widx] <= 1'b1;
        if (s4_r.kind == msxu_pkg::K_MUL) begin
          hi_r <= s4_r.prod[63:32];
          lo_r <= s4_r.prod[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s1_r <= in_pl;
    if (s1_move) s2_r <= s1_res;
    if (s2_move) begin
      s3_r   <= s2_r;
      s3_q_r <= 30'(qprod >> DSH);
    end
    if (s3_move) begin
      s4_r      <= s3_r;
      s4_widx_r <= rem[AW-1:0];
    end
    if (s4_move) begin
      out_r       <= out_nxt;
      lastc_idx_r <= s4_r.widx;
      lastc_val_r <= fin_val;
      dfd_r       <= st_word;
    end
  end

  assign out_bus.valid        = out_v_r;
  assign out_bus.next_pc      = out_r.next_pc;
  assign out_bus.reg_written  = out_r.reg_written;
  assign out_bus.reg_index    = out_r.reg_index;
  assign out_bus.reg_value    = out_r.reg_value;
  assign out_bus.mem_written  = out_r.mem_written;
  assign out_bus.exit_request = out_r.exit_request;
  assign out_bus.print_kind   = out_r.print_kind;
  assign out_bus.print_value  = out_r.print_value;

`ifndef ASSERT_OFF
  a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> !(out_bus.reg_written && out_bus.reg_index == 5'd0))
    else $error("register zero reported written");

  a_retire_excl: assert property (@(posedge clk) disable iff (!rst_n)
    s4_move |-> !(s4_r.memw && s4_r.wr))
    else $error("store and register write retired together");

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> s1_v_r && (hazard || s2_v_r))
    else $error("input stalled with free operand stage");

  a_commit_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_move && s4_r.wr) |=> lastc_v_r && rv_r[lastc_idx_r])
    else $error("retired write not tracked for forwarding");
`endif

endmodule

### rtl/msxu_ram.sv
// ----------------------------------------------------------------------------
// msxu_ram
// Generic RAM: one write port, two registered read ports (old data on collision).
// ----------------------------------------------------------------------------
module msxu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### rtl/msxu_alu.sv
// ----------------------------------------------------------------------------
// msxu_alu
// Operand-stage datapath: ALU, compare, branch/jump target, address, multiply.
// ----------------------------------------------------------------------------
module msxu_alu (
  input  msxu_pkg::in_t  ins,
  input  logic [31:0]    a,
  input  logic [31:0]    b,
  input  logic [31:0]    pc,
  output msxu_pkg::stg_t res
);

  logic [31:0]        simm, zimm, pc4, bpc, jpc;
  logic signed [63:0] prod;

  assign simm = {{16{ins.immediate[15]}}, ins.immediate};
  assign zimm = {16'd0, ins.immediate};
  assign pc4  = pc + 32'd4;
  assign bpc  = pc4 + {simm[29:0], 2'b00};
  assign jpc  = {pc4[31:28], ins.jump_target, 2'b00};
  assign prod = $signed(a) * $signed(b);

  always_comb begin
    res       = '0;
    res.kind  = ins.kind;
    res.pc    = pc4;
    res.sdata = b;
    res.addr  = a + simm;
    res.prod  = prod;
    unique case (ins.kind) inside
      msxu_pkg::K_ADD: begin res.wr = 1'b1; res.widx = ins.dest_reg; res.wval = a + b; end
      msxu_pkg::K_ADDI: begin res.wr = 1'b1; res.widx = ins.src_reg_b; res.wval = a + simm; end
      msxu_pkg::K_SUB: begin res.wr = 1'b1; res.widx = ins.dest_reg; res.wval = a - b; end
      msxu_pkg::K_AND: begin res.wr = 1'b1; res.widx = ins.dest_reg; res.wval = a & b; end
      msxu_pkg::K_OR: begin res.wr = 1'b1; res.widx = ins.dest_reg; res.wval = a | b; end
      msxu_pkg::K_XOR: begin res.wr = 1'b1; res.widx = ins.dest_reg; res.wval = a ^ b; end
      msxu_pkg::K_NOR: begin res.wr = 1'b1; res.widx = ins.dest_reg; res.wval = ~(a | b); end
      msxu_pkg::K_SLT: begin
        res.wr = 1'b1; res.widx = ins.dest_reg;
        res.wval = {31'd0, $signed(a) < $signed(b)};
      end
      msxu_pkg::K_BLT: begin if ($signed(a) < $signed(b)) res.pc = bpc; end
      msxu_pkg::K_BEQ: begin if (a == b) res.pc = bpc; end
      msxu_pkg::K_BNE: begin if (a != b) res.pc = bpc; end
      msxu_pkg::K_SLTI: begin
        res.wr = 1'b1; res.widx = ins.src_reg_b;
        res.wval = {31'd0, $signed(a) < $signed(simm)};
      end
      msxu_pkg::K_ANDI: begin res.wr = 1'b1; res.widx = ins.src_reg_b; res.wval = a & zimm; end
      msxu_pkg::K_ORI: begin res.wr = 1'b1; res.widx = ins.src_reg_b; res.wval = a | zimm; end
      msxu_pkg::K_XORI: begin res.wr = 1'b1; res.widx = ins.src_reg_b; res.wval = a ^ zimm; end
      msxu_pkg::K_LUI: begin
        res.wr = 1'b1; res.widx = ins.src_reg_b; res.wval = {ins.immediate, 16'd0};
      end
      msxu_pkg::K_LW, msxu_pkg::K_LB, msxu_pkg::K_LBU: begin
        res.wr = 1'b1; res.widx = ins.src_reg_b; res.late = 1'b1;
      end
      msxu_pkg::K_SW, msxu_pkg::K_SB: begin res.memw = 1'b1; end
      msxu_pkg::K_SLL: begin res.wr = 1'b1; res.widx = ins.dest_reg; res.wval = b << ins.shift_amount; end
      msxu_pkg::K_SRL: begin res.wr = 1'b1; res.widx = ins.dest_reg; res.wval = b >> ins.shift_amount; end
      msxu_pkg::K_SRA: begin
        res.wr = 1'b1; res.widx = ins.dest_reg;
        res.wval = $unsigned($signed(b) >>> ins.shift_amount);
      end
      msxu_pkg::K_JR: begin res.pc = a; end
      msxu_pkg::K_J: begin res.pc = jpc; end
      msxu_pkg::K_JAL: begin
        res.wr = 1'b1; res.widx = msxu_pkg::RA_INDEX; res.wval = pc4; res.pc = jpc;
      end
      msxu_pkg::K_SYSCALL: begin
        // a holds r2, b holds r4
        if (a == msxu_pkg::SYS_PRINT_INT) begin
          res.pkind = msxu_pkg::PK_INT; res.pval = b;
        end else if (a == msxu_pkg::SYS_PRINT_CHAR) begin
          res.pkind = msxu_pkg::PK_CHAR; res.pval = b;
        end else if (a == msxu_pkg::SYS_EXIT) begin
          res.quit = 1'b1;
        end
      end
      msxu_pkg::K_MFHI, msxu_pkg::K_MFLO: begin
        res.wr = 1'b1; res.widx = ins.dest_reg; res.late = 1'b1;
      end
      msxu_pkg::K_MUL: begin end
      default: begin end
    endcase
    if (res.wr && res.widx == 5'd0) begin
      res.wr   = 1'b0;
      res.late = 1'b0;
    end
    if (!res.wr) begin
      res.widx = 5'd0;
      res.wval = 32'd0;
    end
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the MIPS-subset execute unit: a directed pass over every operation,
// register zero, memory lanes, branches, jumps and syscalls, then random
// instruction streams under three idle patterns and a long result stall.
// Each result is compared with an in-bench predictor of the architectural state.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DMEM_WORDS = 1024;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [4:0] K_UNUSED = 5'd31;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  msxu_in_if  in_bus ();
  msxu_out_if out_bus ();
  msxu_cfg_if cfg_bus ();

  mips_subset_execute_unit #(.DMEM_WORDS(DMEM_WORDS)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  // Predicted architectural state
  logic [31:0]     gpr [32];
  logic [31:0]     pc_q;
  logic [31:0]     hi_q, lo_q;
  logic [31:0]     dmem [DMEM_WORDS];
  logic [3:0]      dmem_lanes [DMEM_WORDS];  // bytes written since reset
  int              touched_words [$];
  msxu_pkg::out_t  expected_q [$];

  int  snd_idle_pct;
  int  rcv_idle_pct;
  int  hold_req;
  int  hold_left;
  int  quiet_cycles;
  bit  failed;

  initial begin
    in_bus.valid = 1'b0;
    in_bus.kind = '0;
    in_bus.dest_reg = '0;
    in_bus.src_reg_a = '0;
    in_bus.src_reg_b = '0;
    in_bus.immediate = '0;
    in_bus.shift_amount = '0;
    in_bus.jump_target = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    hold_req = 0;
    failed = 1'b0;
  end

  task automatic state_reset();
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    for (int i = 0; i < DMEM_WORDS; i++) begin
      dmem[i] = '0;
      dmem_lanes[i] = '0;
    end
    touched_words.delete();
    pc_q = msxu_pkg::RESET_PC;
    hi_q = '0;
    lo_q = '0;
  endtask

  task automatic execute(input msxu_pkg::in_t x, output msxu_pkg::out_t r);
    logic [31:0] a, b, simm, addr, npc, val;
    logic [7:0]  byte_v;
    logic        wr;
    logic [4:0]  widx;
    int          w, sel;
    longint      prod;
    a = gpr[x.src_reg_a];
    b = gpr[x.src_reg_b];
    simm = {{16{x.immediate[15]}}, x.immediate};
    addr = a + simm;
    w = addr[11:2] % DMEM_WORDS;
    sel = (3 - addr[1:0]) * 8;
    byte_v = dmem[w][sel +: 8];
    npc = pc_q + 32'd4;
    wr = 1'b0;
    widx = '0;
    val = '0;
    r = '0;
    case (x.kind)
      msxu_pkg::K_ADD:  begin wr = 1; widx = x.dest_reg; val = a + b; end
      msxu_pkg::K_ADDI: begin wr = 1; widx = x.src_reg_b; val = a + simm; end
      msxu_pkg::K_SUB:  begin wr = 1; widx = x.dest_reg; val = a - b; end
      msxu_pkg::K_AND:  begin wr = 1; widx = x.dest_reg; val = a & b; end
      msxu_pkg::K_OR:   begin wr = 1; widx = x.dest_reg; val = a | b; end
      msxu_pkg::K_XOR:  begin wr = 1; widx = x.dest_reg; val = a ^ b; end
      msxu_pkg::K_NOR:  begin wr = 1; widx = x.dest_reg; val = ~(a | b); end
      msxu_pkg::K_SLT:  begin
        wr = 1; widx = x.dest_reg; val = ($signed(a) < $signed(b)) ? 1 : 0;
      end
      msxu_pkg::K_BLT:  if ($signed(a) < $signed(b)) npc = npc + (simm << 2);
      msxu_pkg::K_BEQ:  if (a == b) npc = npc + (simm << 2);
      msxu_pkg::K_BNE:  if (a != b) npc = npc + (simm << 2);
      msxu_pkg::K_SLTI: begin
        wr = 1; widx = x.src_reg_b; val = ($signed(a) < $signed(simm)) ? 1 : 0;
      end
      msxu_pkg::K_ANDI: begin
        wr = 1; widx = x.src_reg_b; val = a & {16'h0, x.immediate};
      end
      msxu_pkg::K_ORI:  begin
        wr = 1; widx = x.src_reg_b; val = a | {16'h0, x.immediate};
      end
      msxu_pkg::K_XORI: begin
        wr = 1; widx = x.src_reg_b; val = a ^ {16'h0, x.immediate};
      end
      msxu_pkg::K_LUI:  begin wr = 1; widx = x.src_reg_b; val = {x.immediate, 16'h0}; end
      msxu_pkg::K_LW:   begin wr = 1; widx = x.src_reg_b; val = dmem[w]; end
      msxu_pkg::K_SW:   begin
        dmem[w] = b;
        if (dmem_lanes[w] == '0) touched_words.push_back(w);
        dmem_lanes[w] = 4'hf;
        r.mem_written = 1'b1;
      end
      msxu_pkg::K_LB:   begin
        wr = 1; widx = x.src_reg_b; val = {{24{byte_v[7]}}, byte_v};
      end
      msxu_pkg::K_SB:   begin
        dmem[w][sel +: 8] = b[7:0];
        if (dmem_lanes[w] == '0) touched_words.push_back(w);
        dmem_lanes[w][addr[1:0]] = 1'b1;
        r.mem_written = 1'b1;
      end
      msxu_pkg::K_LBU:  begin wr = 1; widx = x.src_reg_b; val = {24'h0, byte_v}; end
      msxu_pkg::K_SLL:  begin wr = 1; widx = x.dest_reg; val = b << x.shift_amount; end
      msxu_pkg::K_SRL:  begin wr = 1; widx = x.dest_reg; val = b >> x.shift_amount; end
      msxu_pkg::K_SRA:  begin
        wr = 1; widx = x.dest_reg; val = $signed(b) >>> x.shift_amount;
      end
      msxu_pkg::K_JR:   npc = a;
      msxu_pkg::K_J:    npc = {npc[31:28], x.jump_target, 2'b00};
      msxu_pkg::K_JAL:  begin
        wr = 1; widx = msxu_pkg::RA_INDEX; val = npc;
        npc = {npc[31:28], x.jump_target, 2'b00};
      end
      msxu_pkg::K_SYSCALL: begin
        if (gpr[msxu_pkg::SYS_REG] == msxu_pkg::SYS_PRINT_INT) begin
          r.print_kind = msxu_pkg::PK_INT; r.print_value = gpr[msxu_pkg::ARG_REG];
        end else if (gpr[msxu_pkg::SYS_REG] == msxu_pkg::SYS_PRINT_CHAR) begin
          r.print_kind = msxu_pkg::PK_CHAR; r.print_value = gpr[msxu_pkg::ARG_REG];
        end else if (gpr[msxu_pkg::SYS_REG] == msxu_pkg::SYS_EXIT) begin
          r.exit_request = 1'b1;
        end
      end
      msxu_pkg::K_MFHI: begin wr = 1; widx = x.dest_reg; val = hi_q; end
      msxu_pkg::K_MFLO: begin wr = 1; widx = x.dest_reg; val = lo_q; end
      msxu_pkg::K_MUL:  begin
        prod = longint'($signed(a)) * longint'($signed(b));
        hi_q = prod[63:32];
        lo_q = prod[31:0];
      end
      default: ;
    endcase
    if (wr && widx != 0) begin
      gpr[widx] = val;
      r.reg_written = 1'b1;
      r.reg_index = widx;
      r.reg_value = val;
    end
    pc_q = npc;
    r.next_pc = npc;
  endtask

  function automatic msxu_pkg::in_t make_instr(logic [4:0] k, logic [4:0] rd,
                                               logic [4:0] rs, logic [4:0] rt,
                                               logic [15:0] imm,
                                               logic [4:0] sh = 0,
                                               logic [25:0] tgt = 0);
    msxu_pkg::in_t x;
    x.kind = k;
    x.dest_reg = rd;
    x.src_reg_a = rs;
    x.src_reg_b = rt;
    x.immediate = imm;
    x.shift_amount = sh;
    x.jump_target = tgt;
    return x;
  endfunction

  function automatic msxu_pkg::in_t random_instr();
    msxu_pkg::in_t x;
    x.kind = 5'($urandom_range(0, 31));
    x.dest_reg = 5'($urandom_range(0, 31));
    x.src_reg_a = 5'($urandom_range(0, 31));
    x.src_reg_b = 5'($urandom_range(0, 31));
    x.immediate = 16'($urandom_range(0, 16'hffff));
    x.shift_amount = 5'($urandom_range(0, 31));
    x.jump_target = 26'($urandom_range(0, 26'h3ffffff));
    return x;
  endfunction

  // Aims a load at bytes already written; falls back to a store otherwise
  task automatic aim_load(inout msxu_pkg::in_t x);
    int w, lane, d, k;
    logic [11:0] want, delta;
    bit found;
    found = 0;
    for (int t = 0; t < 8 && !found && touched_words.size() > 0; t++) begin
      w = touched_words[$urandom_range(0, touched_words.size() - 1)];
      lane = $urandom_range(0, 3);
      if (x.kind == msxu_pkg::K_LW) found = (dmem_lanes[w] == 4'hf);
      else found = dmem_lanes[w][lane];
    end
    if (!found) begin
      x.kind = ($urandom_range(0, 1) != 0) ? msxu_pkg::K_SW : msxu_pkg::K_SB;
      return;
    end
    want = {w[9:0], lane[1:0]};
    delta = want - gpr[x.src_reg_a][11:0];
    d = (delta >= 12'd2048) ? int'(delta) - 4096 : int'(delta);
    k = $urandom_range(0, 14) - 7;
    d = d + k * 4096;
    x.immediate = d[15:0];
  endtask

  task automatic send_instr(input msxu_pkg::in_t x);
    msxu_pkg::out_t r;
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.kind <= x.kind;
    in_bus.dest_reg <= x.dest_reg;
    in_bus.src_reg_a <= x.src_reg_a;
    in_bus.src_reg_b <= x.src_reg_b;
    in_bus.immediate <= x.immediate;
    in_bus.shift_amount <= x.shift_amount;
    in_bus.jump_target <= x.jump_target;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    execute(x, r);
    expected_q.push_back(r);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_start_addr(input logic [31:0] v);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    pc_q = v;
  endtask

  task automatic test_directed();
    send_instr(make_instr(msxu_pkg::K_LUI, 0, 0, 1, 16'hffff));
    send_instr(make_instr(msxu_pkg::K_ORI, 0, 1, 1, 16'hffff));
    send_instr(make_instr(msxu_pkg::K_ADDI, 0, 0, 2, 16'h7fff));
    send_instr(make_instr(msxu_pkg::K_ADDI, 0, 0, 3, 16'h8000));
    send_instr(make_instr(msxu_pkg::K_ADD, 5, 1, 2, 0));
    send_instr(make_instr(msxu_pkg::K_SUB, 6, 3, 2, 0));
    send_instr(make_instr(msxu_pkg::K_AND, 7, 1, 3, 0));
    send_instr(make_instr(msxu_pkg::K_OR, 8, 2, 3, 0));
    send_instr(make_instr(msxu_pkg::K_XOR, 9, 1, 2, 0));
    send_instr(make_instr(msxu_pkg::K_NOR, 10, 2, 0, 0));
    send_instr(make_instr(msxu_pkg::K_SLT, 11, 1, 2, 0));
    send_instr(make_instr(msxu_pkg::K_SLTI, 0, 3, 12, 16'h8000));
    send_instr(make_instr(msxu_pkg::K_ANDI, 0, 1, 13, 16'hffff));
    send_instr(make_instr(msxu_pkg::K_XORI, 0, 1, 14, 16'h8001));
    send_instr(make_instr(msxu_pkg::K_SLL, 15, 0, 1, 0, 5'd31));
    send_instr(make_instr(msxu_pkg::K_SRL, 16, 0, 1, 0, 5'd31));
    send_instr(make_instr(msxu_pkg::K_SRA, 17, 0, 3, 0, 5'd31));
    send_instr(make_instr(msxu_pkg::K_SRA, 17, 0, 2, 0, 5'd0));
    send_instr(make_instr(msxu_pkg::K_MUL, 0, 3, 1, 0));
    send_instr(make_instr(msxu_pkg::K_MFHI, 18, 0, 0, 0));
    send_instr(make_instr(msxu_pkg::K_MFLO, 19, 0, 0, 0));
    send_instr(make_instr(msxu_pkg::K_MUL, 0, 2, 3, 0));
    send_instr(make_instr(msxu_pkg::K_MFHI, 20, 0, 0, 0));
    // register zero keeps its value
    send_instr(make_instr(msxu_pkg::K_ADDI, 0, 1, 0, 16'h0005));
    send_instr(make_instr(msxu_pkg::K_ADD, 21, 0, 0, 0));
    // memory lanes at the top of the address space
    send_instr(make_instr(msxu_pkg::K_SW, 0, 0, 1, 16'hfffc));
    send_instr(make_instr(msxu_pkg::K_SB, 0, 0, 2, 16'hfffd));
    send_instr(make_instr(msxu_pkg::K_LW, 0, 0, 22, 16'hfffc));
    send_instr(make_instr(msxu_pkg::K_LB, 0, 0, 23, 16'hfffd));
    send_instr(make_instr(msxu_pkg::K_LBU, 0, 0, 24, 16'hfffe));
    send_instr(make_instr(msxu_pkg::K_LB, 0, 0, 25, 16'hffff));
    send_instr(make_instr(msxu_pkg::K_BEQ, 0, 0, 0, 16'hffff));
    send_instr(make_instr(msxu_pkg::K_BNE, 0, 0, 0, 16'h7fff));
    send_instr(make_instr(msxu_pkg::K_BLT, 0, 1, 2, 16'h7fff));
    send_instr(make_instr(msxu_pkg::K_BLT, 0, 2, 1, 16'h8000));
    send_instr(make_instr(msxu_pkg::K_J, 0, 0, 0, 0, 0, 26'h3ffffff));
    send_instr(make_instr(msxu_pkg::K_JAL, 0, 0, 0, 0, 0, 26'h0));
    send_instr(make_instr(msxu_pkg::K_JR, 0, 1, 0, 0));
    send_instr(make_instr(msxu_pkg::K_ADDI, 0, 0, 4, 16'hfffb));
    send_instr(make_instr(msxu_pkg::K_ADDI, 0, 0, msxu_pkg::SYS_REG,
                          msxu_pkg::SYS_PRINT_INT[15:0]));
    send_instr(make_instr(msxu_pkg::K_SYSCALL, 0, 0, 0, 0));
    send_instr(make_instr(msxu_pkg::K_ADDI, 0, 0, msxu_pkg::SYS_REG,
                          msxu_pkg::SYS_PRINT_CHAR[15:0]));
    send_instr(make_instr(msxu_pkg::K_SYSCALL, 0, 0, 0, 0));
    send_instr(make_instr(msxu_pkg::K_ADDI, 0, 0, msxu_pkg::SYS_REG,
                          msxu_pkg::SYS_EXIT[15:0]));
    send_instr(make_instr(msxu_pkg::K_SYSCALL, 0, 0, 0, 0));
    send_instr(make_instr(msxu_pkg::K_ADDI, 0, 0, msxu_pkg::SYS_REG, 16'd3));
    send_instr(make_instr(msxu_pkg::K_SYSCALL, 0, 0, 0, 0));
    send_instr(make_instr(K_UNUSED, 0, 0, 0, 0));
  endtask

  task automatic test_random_mix(input int count);
    msxu_pkg::in_t x;
    int  pick;
    for (int n = 0; n < count; n++) begin
      x = random_instr();
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        x.kind = ($urandom_range(0, 2) == 0) ? msxu_pkg::K_LW :
                 (($urandom_range(0, 1) != 0) ? msxu_pkg::K_LB : msxu_pkg::K_LBU);
        aim_load(x);
      end else if (pick < 25) begin
        x.kind = ($urandom_range(0, 1) != 0) ? msxu_pkg::K_SW : msxu_pkg::K_SB;
      end else if (pick < 30) begin
        // syscall, usually with a meaningful service code
        case ($urandom_range(0, 3))
          0: x.immediate = msxu_pkg::SYS_PRINT_INT[15:0];
          1: x.immediate = msxu_pkg::SYS_PRINT_CHAR[15:0];
          2: x.immediate = msxu_pkg::SYS_EXIT[15:0];
          default: ;
        endcase
        send_instr(make_instr(msxu_pkg::K_ADDI, 0, 0, msxu_pkg::SYS_REG, x.immediate));
        x.kind = msxu_pkg::K_SYSCALL;
      end else if (pick < 35) begin
        send_instr(make_instr(msxu_pkg::K_MUL, 0, x.src_reg_a, x.src_reg_b, 0));
        x.kind = ($urandom_range(0, 1) != 0) ? msxu_pkg::K_MFHI : msxu_pkg::K_MFLO;
      end else if (x.kind == msxu_pkg::K_LW || x.kind == msxu_pkg::K_LB ||
                   x.kind == msxu_pkg::K_LBU) begin
        aim_load(x);
      end
      send_instr(x);
    end
  endtask

  task automatic test_backpressure();
    hold_req = 120;
    test_random_mix(60);
  endtask

  // Result side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_req > 0 && hold_left == 0) begin
      out_bus.ready <= 1'b0;
      hold_left <= hold_req;
      hold_req <= 0;
    end else if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_bus.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    msxu_pkg::out_t e;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with no instruction outstanding");
        failed = 1'b1;
      end else begin
        e = expected_q.pop_front();
        check_field("next_pc", e.next_pc, out_bus.next_pc);
        check_field("reg_written", 32'(e.reg_written), 32'(out_bus.reg_written));
        check_field("reg_index", 32'(e.reg_index), 32'(out_bus.reg_index));
        check_field("reg_value", e.reg_value, out_bus.reg_value);
        check_field("mem_written", 32'(e.mem_written), 32'(out_bus.mem_written));
        check_field("exit_request", 32'(e.exit_request), 32'(out_bus.exit_request));
        check_field("print_kind", 32'(e.print_kind), 32'(out_bus.print_kind));
        check_field("print_value", e.print_value, out_bus.print_value);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("mips_subset_execute_unit: mismatch");
      $finish;
    end
  end

  initial begin
    quiet_cycles = 0;
    snd_idle_pct = 13;
    rcv_idle_pct = 74;
    state_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_mix(250);
    drain();

    write_start_addr(32'h0000_0000);
    snd_idle_pct = 74;
    rcv_idle_pct = 13;
    test_random_mix(300);
    drain();

    write_start_addr(32'hffff_ffff);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_mix(150);
    test_backpressure();
    drain();

    write_start_addr($urandom());
    test_random_mix(150);
    drain();

    if (!failed)
      $display("mips_subset_execute_unit: match");
    else
      $display("mips_subset_execute_unit: mismatch");
    $finish;
  end

endmodule
